FILE: src/uds_pkg.sv
// Package for the UDS request server: beat types, service and NRC codes, decode result.
`default_nettype none
package uds_pkg;

   // Input beat: one operation with its request bytes
   typedef struct packed {
      logic [1:0]  operation;
      logic        functional;
      logic [11:0] request_length;
      logic [7:0]  service_id;
      logic [7:0]  req_byte1;
      logic [7:0]  req_byte2;
      logic [7:0]  req_byte3;
      logic [11:0] response_room;
   } req_type;

   // Result beat: one response byte plus per-step flags
   typedef struct packed {
      logic [7:0] resp_byte;
      logic       last_byte;
      logic       byte_valid;
      logic       clear_dtc_strobe;
      logic [1:0] reset_request;
      logic       pass_on;
      logic       session_extended;
   } rsp_type;

   localparam int MSG_BYTES = 6;

   // Decoded step, handed from the decoder to the serializer
   typedef struct packed {
      logic [MSG_BYTES-1:0][7:0] msg;
      logic [2:0]                nbytes;
      logic                      clr;
      logic [1:0]                rst;
      logic                      pass;
      logic                      session_next;
      logic [1:0]                pending_next;
      logic [15:0]               idle_next;
   } dec_type;

   // Operations; the fourth code does nothing
   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_EXECUTE = 2'd2;
   localparam logic [1:0] OP_IDLE    = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_P2     = 2'd0;
   localparam logic [1:0] CSR_P2STAR = 2'd1;
   localparam logic [1:0] CSR_S3     = 2'd2;

   localparam logic [15:0] P2_RESET     = 16'd50;
   localparam logic [15:0] P2STAR_RESET = 16'd500;
   localparam logic [15:0] S3_RESET     = 16'd5000;

   // Service ids
   localparam logic [7:0] SID_SESSION  = 8'h10;
   localparam logic [7:0] SID_ECURESET = 8'h11;
   localparam logic [7:0] SID_CLEARDTC = 8'h14;
   localparam logic [7:0] SID_READDTC  = 8'h19;
   localparam logic [7:0] SID_READDID  = 8'h22;
   localparam logic [7:0] SID_TESTER   = 8'h3E;
   localparam logic [7:0] SID_NEGATIVE = 8'h7F;
   localparam logic [7:0] POS_OFFSET   = 8'h40;

   // Negative response codes
   localparam logic [7:0] NRC_NONE         = 8'h00;
   localparam logic [7:0] NRC_SNS          = 8'h11;
   localparam logic [7:0] NRC_SFNS         = 8'h12;
   localparam logic [7:0] NRC_BAD_LENGTH   = 8'h13;
   localparam logic [7:0] NRC_OUT_OF_RANGE = 8'h31;
   localparam logic [7:0] NRC_SFNS_SESSION = 8'h7E;
   localparam logic [7:0] NRC_SNS_SESSION  = 8'h7F;

   // Sub-functions and reset kinds
   localparam logic [6:0] SUB_DEFAULT  = 7'h01;
   localparam logic [6:0] SUB_EXTENDED = 7'h03;
   localparam logic [6:0] SUB_HARD     = 7'h01;
   localparam logic [6:0] SUB_SOFT     = 7'h03;
   localparam logic [6:0] SUB_ZERO     = 7'h00;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_HARD = 2'd1;
   localparam logic [1:0] PEND_SOFT = 2'd3;

   // Reset kind reported on an execute step
   localparam logic [1:0] EXEC_NONE = 2'd0;
   localparam logic [1:0] EXEC_HARD = 2'd1;
   localparam logic [1:0] EXEC_SOFT = 2'd2;

   localparam logic [23:0] GROUP_ALL = 24'hFFFFFF;
   localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

endpackage
`default_nettype wire

FILE: src/uds_decode.sv
// Request decoder: service dispatch, NRC selection, response bytes and next state.
`default_nettype none
module uds_decode (
   input  wire uds_pkg::req_type req,
   input  wire logic             session_ext,
   input  wire logic [1:0]       pending,
   input  wire logic [15:0]      idle_count,
   input  wire logic [15:0]      p2_ms,
   input  wire logic [15:0]      p2star_10ms,
   input  wire logic [15:0]      s3_ms,
   output      uds_pkg::dec_type dec
);
   import uds_pkg::*;

   logic [7:0] nrc;
   logic       supp;
   logic [6:0] sub;
   logic       quiet;

   always_comb begin
      dec              = '0;
      dec.session_next = session_ext;
      dec.pending_next = pending;
      dec.idle_next    = idle_count;
      nrc              = NRC_NONE;
      supp             = 1'b0;
      sub              = req.req_byte1[6:0];
      quiet            = 1'b0;

      case (req.operation)
         OP_REQUEST: begin
            if (req.request_length != 12'd0) begin
               dec.idle_next = '0;
               case (req.service_id)
                  SID_SESSION: begin
                     if (req.request_length != 12'd2) begin
                        nrc = NRC_BAD_LENGTH;
                     end else if (sub != SUB_DEFAULT && sub != SUB_EXTENDED) begin
                        nrc = NRC_SFNS;
                     end else begin
                        dec.session_next = (sub == SUB_EXTENDED);
                        supp             = req.req_byte1[7];
                        dec.msg[0]       = SID_SESSION + POS_OFFSET;
                        dec.msg[1]       = {1'b0, sub};
                        dec.msg[2]       = p2_ms[15:8];
                        dec.msg[3]       = p2_ms[7:0];
                        dec.msg[4]       = p2star_10ms[15:8];
                        dec.msg[5]       = p2star_10ms[7:0];
                        dec.nbytes       = 3'd6;
                     end
                  end
                  SID_ECURESET: begin
                     if (req.request_length != 12'd2) begin
                        nrc = NRC_BAD_LENGTH;
                     end else if (sub != SUB_HARD && sub != SUB_SOFT) begin
                        nrc = NRC_SFNS;
                     end else if (!session_ext) begin
                        nrc = NRC_SFNS_SESSION;
                     end else begin
                        dec.pending_next = sub[1:0];
                        supp             = req.req_byte1[7];
                        dec.msg[0]       = SID_ECURESET + POS_OFFSET;
                        dec.msg[1]       = {1'b0, sub};
                        dec.nbytes       = 3'd2;
                     end
                  end
                  SID_CLEARDTC: begin
                     if (req.request_length != 12'd4) begin
                        nrc = NRC_BAD_LENGTH;
                     end else if ({req.req_byte1, req.req_byte2, req.req_byte3}
                                  != GROUP_ALL) begin
                        nrc = NRC_OUT_OF_RANGE;
                     end else begin
                        dec.clr    = 1'b1;
                        dec.msg[0] = SID_CLEARDTC + POS_OFFSET;
                        dec.nbytes = 3'd1;
                     end
                  end
                  SID_READDTC, SID_READDID: begin
                     dec.pass = 1'b1;
                  end
                  SID_TESTER: begin
                     if (req.request_length != 12'd2) begin
                        nrc = NRC_BAD_LENGTH;
                     end else if (sub != SUB_ZERO) begin
                        nrc = NRC_SFNS;
                     end else begin
                        supp       = req.req_byte1[7];
                        dec.msg[0] = SID_TESTER + POS_OFFSET;
                        dec.msg[1] = 8'h00;
                        dec.nbytes = 3'd2;
                     end
                  end
                  default: begin
                     nrc = NRC_SNS;
                  end
               endcase

               // Negative answer, suppression and truncation
               quiet = req.functional && (nrc == NRC_SNS || nrc == NRC_SFNS ||
                       nrc == NRC_OUT_OF_RANGE || nrc == NRC_SFNS_SESSION ||
                       nrc == NRC_SNS_SESSION);
               if (nrc != NRC_NONE) begin
                  dec.msg    = '0;
                  dec.nbytes = 3'd0;
                  if (!quiet && req.response_room >= 12'd3) begin
                     dec.msg[0] = SID_NEGATIVE;
                     dec.msg[1] = req.service_id;
                     dec.msg[2] = nrc;
                     dec.nbytes = 3'd3;
                  end
               end else if (supp) begin
                  dec.nbytes = 3'd0;
               end else if ({9'd0, dec.nbytes} > req.response_room) begin
                  dec.nbytes = req.response_room[2:0];
               end
            end
         end
         OP_TICK: begin
            // S3 idle count, saturating
            if (idle_count != IDLE_MAX) begin
               dec.idle_next = idle_count + 16'd1;
            end
            if (session_ext && dec.idle_next >= s3_ms) begin
               dec.session_next = 1'b0;
            end
         end
         OP_EXECUTE: begin
            if (pending != PEND_NONE) begin
               dec.rst          = (pending == PEND_SOFT) ? EXEC_SOFT : EXEC_HARD;
               dec.pending_next = PEND_NONE;
               dec.session_next = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: src/uds_diagnostic_request_server.sv
// UDS diagnostic request server top level: input register, decode, response serializer.
//
//   channel  ports           direction  beat
//   request  req_*           in         one operation (request, tick or execute)
//   response rsp_*           out        one response byte with step flags
//   config   csr_*           in         register write, index 0..2
//
// An operation is accepted into the input register, then decoded into the message buffer
// once the serializer is free, and leaves as 1 to 6 beats, one per cycle while rsp_ready
// is high. A new step loads as the last beat of the previous one is taken, so
// single-beat steps run back to back. req_ready drops only
// while the input register holds an operation waiting on a busy serializer.
// Reset (synchronous) clears session, pending reset and idle count, restores config.
`default_nettype none
module uds_diagnostic_request_server (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire uds_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      uds_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import uds_pkg::*;

   // Configuration registers
   logic [15:0] p2_ff, p2star_ff, s3_ff;

   // Block state
   logic        session_ff, session_in;
   logic [1:0]  pending_ff, pending_in;
   logic [15:0] idle_ff, idle_in;

   // Input register
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;

   // Message buffer / serializer
   logic                      busy_ff, busy_in;
   logic [MSG_BYTES-1:0][7:0] msg_ff;
   logic [2:0]                beats_ff;
   logic [2:0]                idx_ff, idx_in;
   logic                      bytes_ff;
   logic                      clr_ff, pass_ff;
   logic [1:0]                rst_ff;

   dec_type dec;
   logic    last;
   logic    load;

   uds_decode u_decode (
      .req         (in_data_ff),
      .session_ext (session_ff),
      .pending     (pending_ff),
      .idle_count  (idle_ff),
      .p2_ms       (p2_ff),
      .p2star_10ms (p2star_ff),
      .s3_ms       (s3_ff),
      .dec         (dec)
   );

   // Handshake control
   assign last      = (idx_ff == beats_ff - 3'd1);
   assign load      = in_valid_ff && (!busy_ff || (rsp_ready && last));
   assign req_ready = !in_valid_ff || load;
   assign rsp_valid = busy_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && rsp_ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end

      session_in = load ? dec.session_next : session_ff;
      pending_in = load ? dec.pending_next : pending_ff;
      idle_in    = load ? dec.idle_next    : idle_ff;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         busy_ff     <= 1'b0;
         idx_ff      <= '0;
         session_ff  <= 1'b0;
         pending_ff  <= PEND_NONE;
         idle_ff     <= '0;
         p2_ff       <= P2_RESET;
         p2star_ff   <= P2STAR_RESET;
         s3_ff       <= S3_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         busy_ff     <= busy_in;
         idx_ff      <= idx_in;
         session_ff  <= session_in;
         pending_ff  <= pending_in;
         idle_ff     <= idle_in;
         if (csr_we) begin
            case (csr_index)
               CSR_P2:     p2_ff     <= csr_wdata;
               CSR_P2STAR: p2star_ff <= csr_wdata;
               CSR_S3:     s3_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (load) begin
         msg_ff   <= dec.msg;
         beats_ff <= (dec.nbytes == 3'd0) ? 3'd1 : dec.nbytes;
         bytes_ff <= (dec.nbytes != 3'd0);
         clr_ff   <= dec.clr;
         rst_ff   <= dec.rst;
         pass_ff  <= dec.pass;
      end
   end

   // Result beat
   always_comb begin
      rsp_data                  = '0;
      rsp_data.resp_byte        = bytes_ff ? msg_ff[idx_ff] : 8'h00;
      rsp_data.last_byte        = last;
      rsp_data.byte_valid       = bytes_ff;
      rsp_data.clear_dtc_strobe = clr_ff;
      rsp_data.reset_request    = rst_ff;
      rsp_data.pass_on          = pass_ff;
      rsp_data.session_extended = session_ff;
   end

endmodule
`default_nettype wire
